// File: rtl/usbrx_pkg.sv
// Shared types and constants for the USB receive stream deframer.
// Used by the deframing core, the output queue and the top level; no dependencies.
`timescale 1ns / 1ps

package usbrx_pkg;

    // Widths of the stream fields and configuration registers.
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned TAG_W   = 16;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_TAG    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 1'b1;

    // Configuration reset values.
    localparam logic [TAG_W-1:0] STREAM_TAG_RESET    = 16'd19968;
    localparam logic [LEN_W-1:0] MAX_FRAME_LEN_RESET = 16'd2048;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_BAD_TAG = 1'b1;

    // Header byte positions collected before the last tag byte arrives.
    localparam logic [1:0] HDR_LEN_LO = 2'd0;
    localparam logic [1:0] HDR_LEN_HI = 2'd1;
    localparam logic [1:0] HDR_TAG_LO = 2'd2;
    localparam logic [1:0] HDR_TAG_HI = 2'd3;

    // Deframer phase.
    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_PAD     = 2'd2,
        PH_SKIP    = 2'd3
    } phase_t;

    // One result word.
    typedef struct packed {
        logic              event_kind;
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_first;
        logic              frame_last;
    } result_t;

endpackage

// File: rtl/usbrx_deframe_core.sv
// Deframing core: configuration registers, deframer state and the per-byte step.
// Depends on usbrx_pkg; feeds at most one result word per accepted byte to the output queue.
`timescale 1ns / 1ps

module usbrx_deframe_core
    import usbrx_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_accept,
    input  logic [BYTE_W-1:0]    in_byte,
    input  logic                 in_eot,
    output logic                 res_push,
    output result_t              res_word
);

    logic [TAG_W-1:0] stream_tag_reg;
    logic [LEN_W-1:0] max_frame_len_reg;

    phase_t      phase_reg, phase_next;
    logic [23:0] hdr_shift_reg, hdr_shift_next;
    logic [1:0]  hdr_count_reg, hdr_count_next;
    logic [LEN_W-1:0] bytes_rem_reg, bytes_rem_next;
    logic [1:0]  seg_mod4_reg, seg_mod4_next;
    logic [1:0]  pad_left_reg, pad_left_next;
    logic        keep_frame_reg, keep_frame_next;
    logic        frame_start_reg, frame_start_next;

    // Configuration registers, to be written only while the block is idle (the block does not enforce this).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stream_tag_reg    <= STREAM_TAG_RESET;
            max_frame_len_reg <= MAX_FRAME_LEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_STREAM_TAG:    stream_tag_reg    <= cfg_data[TAG_W-1:0];
                CFG_MAX_FRAME_LEN: max_frame_len_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Deframer state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HUNT;
            hdr_shift_reg   <= '0;
            hdr_count_reg   <= '0;
            bytes_rem_reg   <= '0;
            seg_mod4_reg    <= '0;
            pad_left_reg    <= '0;
            keep_frame_reg  <= 1'b0;
            frame_start_reg <= 1'b0;
        end else if (in_accept) begin
            phase_reg       <= phase_next;
            hdr_shift_reg   <= hdr_shift_next;
            hdr_count_reg   <= hdr_count_next;
            bytes_rem_reg   <= bytes_rem_next;
            seg_mod4_reg    <= seg_mod4_next;
            pad_left_reg    <= pad_left_next;
            keep_frame_reg  <= keep_frame_next;
            frame_start_reg <= frame_start_next;
        end
    end

    // One step of the deframer for the byte at the input.
    always_comb begin
        logic [LEN_W-1:0] hdr_len;
        logic [TAG_W-1:0] hdr_tag;
        logic             last_byte;
        logic [1:0]       seg_inc;

        hdr_len   = hdr_shift_reg[15:0];
        hdr_tag   = {in_byte, hdr_shift_reg[23:16]};
        last_byte = (bytes_rem_reg <= LEN_W'(1));
        seg_inc   = seg_mod4_reg + 2'd1;

        phase_next       = phase_reg;
        hdr_shift_next   = hdr_shift_reg;
        hdr_count_next   = hdr_count_reg;
        bytes_rem_next   = bytes_rem_reg;
        seg_mod4_next    = seg_mod4_reg;
        pad_left_next    = pad_left_reg;
        keep_frame_next  = keep_frame_reg;
        frame_start_next = frame_start_reg;
        res_push         = 1'b0;
        res_word         = '0;

        unique case (phase_reg)
            PH_HUNT: begin
                if (hdr_count_reg != HDR_TAG_HI) begin
                    // Collect one of the first three header bytes.
                    case (hdr_count_reg)
                        HDR_LEN_LO: hdr_shift_next[7:0]   = in_byte;
                        HDR_LEN_HI: hdr_shift_next[15:8]  = in_byte;
                        default:    hdr_shift_next[23:16] = in_byte;
                    endcase
                    hdr_count_next = hdr_count_reg + 2'd1;
                    if (in_eot) begin
                        hdr_shift_next = '0;
                        hdr_count_next = '0;
                    end
                end else begin
                    // Last tag byte: the header is complete.
                    hdr_shift_next = '0;
                    hdr_count_next = '0;
                    if (hdr_tag != stream_tag_reg) begin
                        res_push            = 1'b1;
                        res_word.event_kind = KIND_BAD_TAG;
                        phase_next          = in_eot ? PH_HUNT : PH_SKIP;
                    end else begin
                        bytes_rem_next   = hdr_len;
                        keep_frame_next  = (hdr_len <= max_frame_len_reg);
                        frame_start_next = 1'b1;
                        seg_mod4_next    = '0;
                        phase_next       = (hdr_len == '0) ? PH_HUNT : PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (keep_frame_reg) begin
                    res_push              = 1'b1;
                    res_word.event_kind   = KIND_PAYLOAD;
                    res_word.payload_byte = in_byte;
                    res_word.frame_first  = frame_start_reg;
                    res_word.frame_last   = last_byte;
                end
                frame_start_next = 1'b0;
                bytes_rem_next   = last_byte ? '0 : bytes_rem_reg - LEN_W'(1);
                seg_mod4_next    = seg_inc;
                if (last_byte) begin
                    // Padding up to the next 4-byte boundary of the segment.
                    pad_left_next = 2'd0 - seg_inc;
                    phase_next    = (in_eot || seg_inc == 2'd0) ? PH_HUNT : PH_PAD;
                end
            end
            PH_PAD: begin
                pad_left_next = pad_left_reg - 2'd1;
                if (pad_left_next == 2'd0 || in_eot) begin
                    phase_next = PH_HUNT;
                end
            end
            PH_SKIP: begin
                if (in_eot) begin
                    phase_next = PH_HUNT;
                end
            end
            default: phase_next = PH_HUNT;
        endcase

        // Segment alignment restarts with each transfer.
        if (in_eot) begin
            seg_mod4_next = '0;
        end

        res_push = res_push & in_accept;
    end

    // Header bytes are only held while hunting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_HUNT) |-> (hdr_count_reg == 2'd0))
        else $error("header count nonzero outside hunt phase");

    // A payload phase always has bytes left to take.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |-> (bytes_rem_reg != '0))
        else $error("payload phase with no bytes remaining");

    // The padding phase always has padding left to skip.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAD) |-> (pad_left_reg != 2'd0))
        else $error("padding phase with no padding left");

    // A bad tag result carries no frame marks.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_push && res_word.event_kind == KIND_BAD_TAG)
            |-> (!res_word.frame_first && !res_word.frame_last))
        else $error("bad tag result with frame marks");

endmodule

// File: rtl/usbrx_out_queue.sv
// Two-word output stage: a result register with a skid register behind it.
// Depends on usbrx_pkg; lets the core take a byte while a result waits downstream.
`timescale 1ns / 1ps

module usbrx_out_queue
    import usbrx_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_word,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_word
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_word_reg, out_word_next;
    result_t skid_word_reg, skid_word_next;
    logic    refill;

    assign room      = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Move words forward whenever the result register empties.
    always_comb begin
        refill          = !out_valid_reg || out_ready;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (refill) begin
            out_valid_next  = skid_valid_reg || push;
            skid_valid_next = skid_valid_reg && push;
            out_word_next   = skid_valid_reg ? skid_word_reg : push_word;
            if (skid_valid_reg && push) begin
                skid_word_next = push_word;
            end
        end else begin
            out_valid_next  = 1'b1;
            skid_valid_next = skid_valid_reg || push;
            if (push) begin
                skid_word_next = push_word;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    // The skid register only fills behind a held result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without a result word");

    // No word arrives while both slots are full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && skid_valid_reg))
        else $error("push into a full output stage");

    // A stalled result word is followed by a full skid only if a word was pushed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready && !push && !skid_valid_reg) |=> !skid_valid_reg)
        else $error("skid filled without a push");

endmodule

// File: rtl/usb_rx_stream_deframer.sv
// Top level of the USB receive stream deframer.
// Depends on usbrx_pkg, usbrx_deframe_core and usbrx_out_queue.
`timescale 1ns / 1ps

// The deframer takes one received byte per clock and finds length-prefixed
// frames: a 4-byte header (16-bit little-endian length, 16-bit tag) followed
// by the payload and padding to a 4-byte boundary within the transfer. Each
// byte is handled in the cycle it is accepted. s_tready falls only when
// both words of the output stage (result register and skid register) are
// full, so with m_tready held high the block sustains one byte per clock.
// Payload bytes of frames up to max_frame_len come out with first and last
// marks; a header with a wrong tag gives one error word and the rest of that
// transfer is dropped. Configuration is written through cfg_wr_en; the user
// writes it only while the stream is idle; the block does not enforce this.

module usb_rx_stream_deframer
    import usbrx_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port.
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // Received byte stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,   // end_of_transfer
    // Deframed output.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] payload_byte
    output logic [1:0]           m_tuser,   // [0] event_kind, [1] frame_first
    output logic                 m_tlast    // frame_last
);

    logic    in_accept;
    logic    res_push;
    result_t res_word;
    result_t out_word;
    logic    room;

    assign in_accept = s_tvalid && room;
    assign s_tready  = room;

    // Per-byte deframing step and state.
    usbrx_deframe_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_eot    (s_tlast),
        .res_push  (res_push),
        .res_word  (res_word)
    );

    // Output register with skid.
    usbrx_out_queue u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_word (res_word),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    // Pack the result word onto the stream ports.
    assign m_tdata = out_word.payload_byte;
    assign m_tuser = {out_word.frame_first, out_word.event_kind};
    assign m_tlast = out_word.frame_last;

endmodule

// File: tb/deframer_checker.sv
// Checker for the USB receive stream deframer: watches the byte stream, the
// configuration port and the result stream, predicts every result word and compares.
// Depends on usbrx_pkg for the result layout, phase encoding and register indexes.
`timescale 1ns / 1ps

module deframer_checker
    import usbrx_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,   // end_of_transfer
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [7:0]           m_tdata,   // [7:0] payload_byte
    input  logic [1:0]           m_tuser,   // [0] event_kind, [1] frame_first
    input  logic                 m_tlast,   // frame_last
    output int                   fail_count,
    output int                   pending_results,
    output int                   words_checked,
    output int                   tag_errors
);

    // Configuration as the block should currently hold it.
    logic [TAG_W-1:0] tag_cfg;
    logic [LEN_W-1:0] max_len_cfg;

    // Deframing state of the prediction.
    phase_t           stage;
    logic [23:0]      hdr_bytes;
    logic [1:0]       hdr_fill;
    logic [LEN_W-1:0] frame_left;
    logic [1:0]       seg_count;
    logic [1:0]       pad_count;
    logic             pass_frame;
    logic             first_pending;

    result_t expected_results[$];
    int      mismatches;
    int      checked;
    int      bad_tags;

    // Advance the prediction by one accepted byte and queue any result it causes.
    task automatic deframe_byte(input logic [7:0] b, input logic eot);
        logic        last_byte;
        logic [15:0] tag_seen;
        result_t     r;
        case (stage)
            PH_HUNT: begin
                if (hdr_fill != HDR_TAG_HI) begin
                    hdr_bytes[8*hdr_fill +: 8] = b;
                    hdr_fill = hdr_fill + 2'd1;
                    // A header cut short by the transfer end is dropped.
                    if (eot) begin
                        hdr_bytes = '0;
                        hdr_fill  = HDR_LEN_LO;
                    end
                end else begin
                    tag_seen = {b, hdr_bytes[23:16]};
                    if (tag_seen != tag_cfg) begin
                        r.event_kind   = KIND_BAD_TAG;
                        r.payload_byte = '0;
                        r.frame_first  = 1'b0;
                        r.frame_last   = 1'b0;
                        expected_results.push_back(r);
                        stage = eot ? PH_HUNT : PH_SKIP;
                    end else begin
                        frame_left    = hdr_bytes[15:0];
                        pass_frame    = (hdr_bytes[15:0] <= max_len_cfg);
                        first_pending = 1'b1;
                        seg_count     = 2'd0;
                        stage         = (hdr_bytes[15:0] == '0) ? PH_HUNT : PH_PAYLOAD;
                    end
                    hdr_bytes = '0;
                    hdr_fill  = HDR_LEN_LO;
                end
            end
            PH_PAYLOAD: begin
                last_byte = (frame_left <= 16'd1);
                if (pass_frame) begin
                    r.event_kind   = KIND_PAYLOAD;
                    r.payload_byte = b;
                    r.frame_first  = first_pending;
                    r.frame_last   = last_byte;
                    expected_results.push_back(r);
                end
                first_pending = 1'b0;
                frame_left    = last_byte ? '0 : frame_left - 16'd1;
                seg_count     = seg_count + 2'd1;
                // Padding brings the segment up to a 4-byte boundary.
                if (last_byte) begin
                    pad_count = 2'd0 - seg_count;
                    stage     = (eot || pad_count == 2'd0) ? PH_HUNT : PH_PAD;
                end
            end
            PH_PAD: begin
                pad_count = pad_count - 2'd1;
                if (pad_count == 2'd0 || eot)
                    stage = PH_HUNT;
            end
            default: begin
                if (eot)
                    stage = PH_HUNT;
            end
        endcase
        // Segment counting restarts with every transfer.
        if (eot)
            seg_count = 2'd0;
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    // Results are checked before the byte of the same edge is predicted: a byte's
    // result passes through the output stage registers before it shows.
    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            tag_cfg       = STREAM_TAG_RESET;
            max_len_cfg   = MAX_FRAME_LEN_RESET;
            stage         = PH_HUNT;
            hdr_bytes     = '0;
            hdr_fill      = HDR_LEN_LO;
            frame_left    = '0;
            seg_count     = 2'd0;
            pad_count     = 2'd0;
            pass_frame    = 1'b0;
            first_pending = 1'b0;
            expected_results.delete();
            mismatches    = 0;
            checked       = 0;
            bad_tags      = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_STREAM_TAG)
                    tag_cfg = cfg_data[TAG_W-1:0];
                else if (cfg_index == CFG_MAX_FRAME_LEN)
                    max_len_cfg = cfg_data[LEN_W-1:0];
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $error("result word with nothing expected: kind %0d, byte 0x%02h",
                           m_tuser[0], m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("event_kind", want.event_kind, m_tuser[0]);
                    compare_field("payload_byte", want.payload_byte, m_tdata);
                    compare_field("frame_first", want.frame_first, m_tuser[1]);
                    compare_field("frame_last", want.frame_last, m_tlast);
                    checked++;
                    if (want.event_kind == KIND_BAD_TAG)
                        bad_tags++;
                end
            end
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata, s_tlast);
        end
        fail_count      <= mismatches;
        pending_results <= expected_results.size();
        words_checked   <= checked;
        tag_errors      <= bad_tags;
    end

endmodule

// File: tb/testbench.sv
// Top of the deframer testbench: clock, reset, byte stream stimulus, result sink and verdict.
// Depends on usbrx_pkg, usb_rx_stream_deframer and deframer_checker.
`timescale 1ns / 1ps

module testbench;
    import usbrx_pkg::*;

    localparam int ITEM_TARGET     = 800;
    localparam int HOLD_OFF_CYCLES = 60;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } rx_word_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_STREAM_TAG;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;   // [7:0] data_byte
    logic                 s_tlast   = 1'b0; // end_of_transfer
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;          // [7:0] payload_byte
    logic [1:0]           m_tuser;          // [0] event_kind, [1] frame_first
    logic                 m_tlast;          // frame_last

    int fail_count;
    int pending_results;
    int words_checked;
    int tag_errors;

    rx_word_t stream_bytes[$];
    int       items_sent    = 0;
    int       sender_gaps   = 0;
    logic     hold_off_req  = 1'b0;
    logic     hold_off_done = 1'b0;

    usb_rx_stream_deframer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    deframer_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .words_checked   (words_checked),
        .tag_errors      (tag_errors)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3000000;
        $display("[usb_rx_stream_deframer] ERROR");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        rx_word_t w;
        w.data = b;
        w.last = last;
        stream_bytes.push_back(w);
    endtask

    // Mark the most recently queued byte as the end of its transfer.
    task automatic end_transfer();
        rx_word_t w;
        w = stream_bytes.pop_back();
        w.last = 1'b1;
        stream_bytes.push_back(w);
    endtask

    // Random bytes closing with a transfer end.
    task automatic queue_noise(input int n);
        repeat (n) push_byte(8'($urandom), 1'b0);
        end_transfer();
    endtask

    // Header: little-endian length, then little-endian tag.
    task automatic queue_header(input logic [15:0] len, input logic [15:0] tag,
                                input logic last);
        push_byte(len[7:0], 1'b0);
        push_byte(len[15:8], 1'b0);
        push_byte(tag[7:0], 1'b0);
        push_byte(tag[15:8], last);
    endtask

    // A well-formed frame. split_at > 0 ends the transfer after that many payload
    // bytes; end_mode 1 ends the transfer after the padding, 2 inside the padding.
    task automatic queue_frame(input int len, input logic [15:0] tag, input int split_at,
                               input int end_mode);
        int seg;
        int pad;
        queue_header(len[15:0], tag, len == 0 && end_mode != 0);
        seg = 0;
        for (int i = 1; i <= len; i++) begin
            seg++;
            push_byte(8'($urandom), i == split_at && i < len);
            if (i == split_at && i < len)
                seg = 0;
        end
        if (len > 0) begin
            pad = (4 - seg % 4) % 4;
            if (end_mode == 2 && pad > 1)
                pad = $urandom_range(1, pad - 1);
            repeat (pad) push_byte(8'($urandom), 1'b0);
            if (end_mode != 0)
                end_transfer();
        end
    endtask

    // Offer the queued words in bursts of random length with random gaps.
    task automatic send_stream();
        rx_word_t w;
        int       burst_left;
        burst_left = $urandom_range(1, 24);
        while (stream_bytes.size() != 0) begin
            w = stream_bytes.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= w.data;
            s_tlast  <= w.last;
            do @(posedge aclk); while (!s_tready);
            items_sent++;
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if (sender_gaps != 0) begin
                    s_tvalid <= 1'b0;
                    s_tdata  <= 8'($urandom);
                    repeat ($urandom_range(1, sender_gaps == 1 ? 3 : 12)) @(posedge aclk);
                end
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // Wait until every expected word has come, then let the pipeline settle.
    task automatic wait_idle(input int settle);
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // Both registers are written on back-to-back edges.
    task automatic program_deframer(input logic [15:0] tag, input logic [15:0] max_len);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_STREAM_TAG;
        cfg_data  <= tag;
        @(posedge aclk);
        cfg_index <= CFG_MAX_FRAME_LEN;
        cfg_data  <= max_len;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Result sink: it switches among four ready patterns at random, and it
    // holds off for a long stretch once when asked.
    initial begin : result_sink
        int cyc;
        int pattern;
        cyc = 0;
        pattern = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (hold_off_req && !hold_off_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_done = 1'b1;
            end
            if (cyc % 300 == 0)
                pattern = $urandom_range(0, 3);
            case (pattern)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= (cyc % 5 < 3);
                default: m_tready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    initial begin : stimulus
        logic [15:0] tag;
        logic [15:0] max_len;
        int          phases;
        int          pick;
        int          len;
        int          split;
        int          end_mode;
        logic        bad_last;
        phases = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words under the reset configuration.
        // Two-byte frame with extreme payload values, transfer ending on its last byte.
        queue_header(16'd2, STREAM_TAG_RESET, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        // Zero-length frame: no result, no padding.
        queue_header(16'd0, STREAM_TAG_RESET, 1'b0);
        // Header cut off by the transfer end.
        push_byte(8'h01, 1'b0);
        push_byte(8'h00, 1'b1);
        // Bad tag on the last byte of a transfer: hunting resumes at once.
        queue_header(16'd3, ~STREAM_TAG_RESET, 1'b1);
        // Bad tag in mid transfer: the rest of the transfer is dropped.
        queue_header(16'hFFFF, 16'hFFFF, 1'b0);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h5A, 1'b1);
        send_stream();
        wait_idle(4);
        phases++;

        // Random phases, each under a configuration of its own.
        while (items_sent < ITEM_TARGET) begin
            case (phases)
                1: begin
                    tag     = 16'h0000;
                    max_len = 16'h0000;
                end
                2: begin
                    tag     = 16'hFFFF;
                    max_len = 16'hFFFF;
                end
                3: begin
                    tag     = STREAM_TAG_RESET;
                    max_len = MAX_FRAME_LEN_RESET;
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: tag = STREAM_TAG_RESET;
                        1: tag = 16'h0000;
                        2: tag = 16'hFFFF;
                        default: tag = 16'($urandom);
                    endcase
                    case ($urandom_range(0, 3))
                        0: max_len = 16'h0000;
                        1: max_len = 16'hFFFF;
                        2: max_len = MAX_FRAME_LEN_RESET;
                        default: max_len = 16'($urandom_range(1, 12));
                    endcase
                end
            endcase
            program_deframer(tag, max_len);
            sender_gaps = $urandom_range(0, 2);

            if (phases == 3) begin
                // A long frame offered without gaps while the sink holds off.
                sender_gaps  = 0;
                hold_off_req = 1'b1;
                queue_frame(120, tag, 0, 1);
            end else begin
                repeat (14) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 65) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 85)
                            len = $urandom_range(0, 12);
                        else if (pick < 98)
                            len = $urandom_range(13, 40);
                        else
                            len = $urandom_range(100, 300);
                        split = 0;
                        if (len >= 2 && $urandom_range(0, 3) == 0)
                            split = $urandom_range(1, len - 1);
                        pick = $urandom_range(0, 19);
                        end_mode = (pick < 10) ? 0 : (pick < 16) ? 1 : 2;
                        queue_frame(len, tag, split, end_mode);
                    end else if (pick < 78) begin
                        // Header with one tag bit wrong.
                        bad_last = 1'($urandom_range(0, 1));
                        queue_header(16'($urandom), tag ^ (16'd1 << $urandom_range(0, 15)),
                                     bad_last);
                        if (!bad_last)
                            queue_noise($urandom_range(1, 6));
                    end else if (pick < 88) begin
                        // Partial header.
                        queue_noise($urandom_range(1, 3));
                    end else begin
                        // Raw noise with scattered transfer ends.
                        repeat ($urandom_range(1, 10))
                            push_byte(8'($urandom), $urandom_range(0, 2) == 0);
                        queue_noise(1);
                    end
                end
            end
            send_stream();
            wait_idle(4);
            phases++;
        end

        wait_idle(8);
        $display("Run covered %0d bytes in %0d phases; %0d result words checked,",
                 items_sent, phases, words_checked);
        $display("%0d of them bad tags. Long sink hold-off with the input stalled: %s.",
                 tag_errors, hold_off_done ? "exercised" : "not reached");
        if (fail_count == 0 && pending_results == 0)
            $display("[usb_rx_stream_deframer] OK");
        else
            $display("[usb_rx_stream_deframer] ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/usbrx_pkg.sv
rtl/usbrx_deframe_core.sv
rtl/usbrx_out_queue.sv
rtl/usb_rx_stream_deframer.sv
tb/deframer_checker.sv
tb/testbench.sv
